// ===== rtl/ckse_pkg.sv =====
// shared types and constants of the color key sprite store encoder
`timescale 1ns / 1ps

package ckse_pkg;

  localparam int MAX_TILE_WIDTH_DEF  = 256;
  localparam int MAX_FRAME_WIDTH_DEF = 4096;
  localparam int DWORD_BYTES         = 4;
  localparam int QUEUE_DEPTH         = 2;
  localparam int NUM_SLOTS           = 5;

  localparam logic [31:0] COLOR_KEY_RST   = 32'd0;
  localparam logic [2:0]  PIXEL_BYTES_RST = 3'd1;
  localparam logic [12:0] FRAME_WIDTH_RST = 13'd320;
  localparam logic [8:0]  TILE_WIDTH_RST  = 9'd16;

  typedef enum logic [2:0] {
    KIND_ADVANCE = 3'd0,
    KIND_DWORD   = 3'd1,
    KIND_WORD    = 3'd2,
    KIND_BYTE    = 3'd3,
    KIND_RETURN  = 3'd4
  } record_kind_e;

  typedef enum logic [1:0] {
    CFG_COLOR_KEY   = 2'd0,
    CFG_PIXEL_BYTES = 2'd1,
    CFG_FRAME_WIDTH = 2'd2,
    CFG_TILE_WIDTH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_TRANSP = 2'd1,
    RUN_OPAQUE = 2'd2
  } run_mode_e;

  // every record that one pixel causes, in emission order
  typedef struct packed {
    logic        adv_en;
    logic [31:0] adv_val;
    logic        dw_en;
    logic [9:0]  dw_off;
    logic [31:0] dw_val;
    logic [1:0]  tail_cnt;
    logic [9:0]  tail_off;
    logic [23:0] tail_bytes;
    logic        ret_en;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/ckse_front.sv =====
// front end: config registers, pixel classification and run state
`timescale 1ns / 1ps

module ckse_front #(
  parameter int MAX_TILE_WIDTH  = ckse_pkg::MAX_TILE_WIDTH_DEF,
  parameter int MAX_FRAME_WIDTH = ckse_pkg::MAX_FRAME_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            pixel_value_i,
  input  logic                   row_end_i,
  input  logic                   tile_end_i,
  input  ckse_pkg::queue_stat_t  q_stat_i,
  output logic                   q_push_o,
  output ckse_pkg::desc_t        q_desc_o
);

  logic [31:0] key_q;
  logic [2:0]  pb_q;
  logic [12:0] fw_q;
  logic [8:0]  tw_q;

  ckse_pkg::run_mode_e mode_q, mode_d;
  logic [31:0] pend_q, pend_d;
  logic [23:0] lb_q, lb_d;
  logic [1:0]  lc_q, lc_d;
  logic [10:0] ro_q, ro_d;

  logic [2:0]  pb_w;
  logic [12:0] fw_w;
  logic [8:0]  tw_w;

  always_comb begin
    pb_w = cfg_wdata_i[2:0];
    if (pb_w == 3'd0) pb_w = 3'd1;
    if (pb_w > 3'd4) pb_w = 3'd4;
    fw_w = cfg_wdata_i[12:0];
    if (fw_w == 13'd0) fw_w = 13'd1;
    if (32'(fw_w) > 32'(MAX_FRAME_WIDTH)) fw_w = 13'(MAX_FRAME_WIDTH);
    tw_w = cfg_wdata_i[8:0];
    if (tw_w == 9'd0) tw_w = 9'd1;
    if (32'(tw_w) > 32'(MAX_TILE_WIDTH)) tw_w = 9'(MAX_TILE_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= ckse_pkg::COLOR_KEY_RST;
      pb_q  <= ckse_pkg::PIXEL_BYTES_RST;
      fw_q  <= ckse_pkg::FRAME_WIDTH_RST;
      tw_q  <= ckse_pkg::TILE_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (ckse_pkg::cfg_idx_e'(cfg_index_i))
        ckse_pkg::CFG_COLOR_KEY:   key_q <= cfg_wdata_i;
        ckse_pkg::CFG_PIXEL_BYTES: pb_q  <= pb_w;
        ckse_pkg::CFG_FRAME_WIDTH: fw_q  <= fw_w;
        ckse_pkg::CFG_TILE_WIDTH:  tw_q  <= tw_w;
      endcase
    end
  end

  logic [31:0] mask, pix;
  logic        opaque, new_run, row_done, flush_old, flush_new;
  logic [23:0] lb0;
  logic [1:0]  lc0;
  logic [10:0] ro0, ro1;
  logic [55:0] acc, acc1;
  logic [2:0]  total, total1;
  logic [31:0] skip, pend_inc;
  logic        accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign skip       = {19'd0, fw_q} - {23'd0, tw_q};

  always_comb begin
    unique case (pb_q)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    pix      = pixel_value_i & mask;
    opaque   = pix != (key_q & mask);
    new_run  = mode_q != ckse_pkg::RUN_OPAQUE;
    row_done = row_end_i || tile_end_i;

    // a new run starts from an empty packer
    lb0   = new_run ? 24'd0 : lb_q;
    lc0   = new_run ? 2'd0 : lc_q;
    ro0   = new_run ? 11'd0 : ro_q;
    acc   = {32'd0, lb0} | ({24'd0, pix} << {lc0, 3'b000});
    total = {1'b0, lc0} + pb_q;

    q_desc_o         = '0;
    q_desc_o.adv_en  = opaque && new_run && (pend_q != 32'd0);
    q_desc_o.adv_val = pend_q * {29'd0, pb_q};
    q_desc_o.dw_off  = ro0[9:0];
    q_desc_o.dw_val  = acc[31:0];

    if (total >= 3'(ckse_pkg::DWORD_BYTES)) begin
      q_desc_o.dw_en = opaque;
      ro1    = ro0 + 11'(ckse_pkg::DWORD_BYTES);
      acc1   = acc >> 32;
      total1 = total - 3'(ckse_pkg::DWORD_BYTES);
    end else begin
      ro1    = ro0;
      acc1   = acc;
      total1 = total;
    end

    // tail of the previous run on a transparent pixel, or of this run at row end
    flush_old = !opaque && (mode_q == ckse_pkg::RUN_OPAQUE);
    flush_new = opaque && row_done;
    if (flush_old) begin
      q_desc_o.tail_cnt   = lc_q;
      q_desc_o.tail_off   = ro_q[9:0];
      q_desc_o.tail_bytes = lb_q;
    end else if (flush_new) begin
      q_desc_o.tail_cnt   = total1[1:0];
      q_desc_o.tail_off   = ro1[9:0];
      q_desc_o.tail_bytes = acc1[23:0];
    end
    q_desc_o.ret_en = tile_end_i;

    if (opaque) begin
      mode_d   = ckse_pkg::RUN_OPAQUE;
      lb_d     = acc1[23:0];
      lc_d     = total1[1:0];
      ro_d     = ro1;
      // the advance restarts at the first pixel of a run and counts on through it
      pend_inc = new_run ? 32'd1 : pend_q + 32'd1;
    end else begin
      mode_d   = ckse_pkg::RUN_TRANSP;
      lb_d     = flush_old ? 24'd0 : lb_q;
      lc_d     = flush_old ? 2'd0 : lc_q;
      ro_d     = flush_old ? 11'd0 : ro_q;
      pend_inc = pend_q + 32'd1;
    end
    pend_d = pend_inc;

    if (row_done) begin
      mode_d = ckse_pkg::RUN_NONE;
      if (flush_new) begin
        lb_d = 24'd0;
        lc_d = 2'd0;
        ro_d = 11'd0;
      end
      if (!tile_end_i) pend_d = pend_inc + skip;
    end
    if (tile_end_i) begin
      pend_d = 32'd0;
      lb_d   = 24'd0;
      lc_d   = 2'd0;
      ro_d   = 11'd0;
    end
  end

  assign q_push_o = accept && (q_desc_o.adv_en || q_desc_o.dw_en ||
                               (q_desc_o.tail_cnt != 2'd0) || q_desc_o.ret_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ckse_pkg::RUN_NONE;
      pend_q <= 32'd0;
      lb_q   <= 24'd0;
      lc_q   <= 2'd0;
      ro_q   <= 11'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      lb_q   <= lb_d;
      lc_q   <= lc_d;
      ro_q   <= ro_d;
    end
  end

endmodule

// ===== rtl/ckse_queue.sv =====
// short descriptor queue between front and back end
`timescale 1ns / 1ps

module ckse_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ckse_pkg::desc_t       push_desc_i,
  input  logic                  pop_i,
  output ckse_pkg::desc_t       head_o,
  output ckse_pkg::queue_stat_t stat_o
);

  localparam int DEPTH = ckse_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ckse_pkg::desc_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = cnt_q == CNT_W'(DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ptr_next(wr_q);
      if (do_pop) rd_q <= ptr_next(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/ckse_back.sv =====
// back end: expands one descriptor into records through the output register
`timescale 1ns / 1ps

module ckse_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ckse_pkg::desc_t       head_i,
  input  ckse_pkg::queue_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            record_kind_o,
  output logic [9:0]            byte_offset_o,
  output logic [31:0]           record_value_o,
  output logic                  last_of_run_o
);

  localparam int NS = ckse_pkg::NUM_SLOTS;

  ckse_pkg::desc_t cur_q;
  logic [NS-1:0]   rem_q, rem_d, sel, rem_after, head_rem;
  logic            advance, need_load;

  logic        out_valid_q;
  ckse_pkg::record_kind_e kind_q, kind_d;
  logic [9:0]  off_q, off_d;
  logic [31:0] val_q, val_d;
  logic        last_q;

  // slot order: advance, dword, first tail store, second tail store, return
  assign head_rem = {head_i.ret_en, head_i.tail_cnt == 2'd3, head_i.tail_cnt != 2'd0,
                     head_i.dw_en, head_i.adv_en};

  assign sel       = rem_q & (~rem_q + NS'(1));
  assign rem_after = rem_q & ~sel;
  assign advance   = (rem_q != '0) && (!out_valid_q || out_ready_i);
  assign need_load = (rem_q == '0) || (advance && (rem_after == '0));
  assign pop_o     = need_load && !q_stat_i.empty;

  always_comb begin
    kind_d = ckse_pkg::KIND_RETURN;
    off_d  = 10'd0;
    val_d  = 32'd0;
    if (sel[0]) begin
      kind_d = ckse_pkg::KIND_ADVANCE;
      val_d  = cur_q.adv_val;
    end else if (sel[1]) begin
      kind_d = ckse_pkg::KIND_DWORD;
      off_d  = cur_q.dw_off;
      val_d  = cur_q.dw_val;
    end else if (sel[2]) begin
      off_d = cur_q.tail_off;
      if (cur_q.tail_cnt == 2'd2) begin
        kind_d = ckse_pkg::KIND_WORD;
        val_d  = {16'd0, cur_q.tail_bytes[15:0]};
      end else begin
        kind_d = ckse_pkg::KIND_BYTE;
        val_d  = {24'd0, cur_q.tail_bytes[7:0]};
      end
    end else if (sel[3]) begin
      kind_d = ckse_pkg::KIND_WORD;
      off_d  = cur_q.tail_off + 10'd1;
      val_d  = {16'd0, cur_q.tail_bytes[23:8]};
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (pop_o) rem_d = head_rem;
    else if (advance) rem_d = rem_after;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (advance) begin
      kind_q <= kind_d;
      off_q  <= off_d;
      val_q  <= val_d;
      last_q <= rem_after == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_kind_o  = kind_q;
  assign byte_offset_o  = off_q;
  assign record_value_o = val_q;
  assign last_of_run_o  = last_q;

endmodule

// ===== rtl/color_key_sprite_store_encoder_unit.sv =====
// top level of the color key sprite store encoder
// path: a pixel's descriptor is queued, loaded into the back end, and each record is registered at the output
// throughput: one pixel per cycle while each pixel makes at most one record and the receiver
//   is ready; a pixel with n records (up to five) holds the back end until all n are out, one
//   record per cycle out of the single output register, with a two-descriptor queue absorbing the burst
// reset: rst_ni low clears run state, queue and output valid and restores default config
`timescale 1ns / 1ps

module color_key_sprite_store_encoder_unit #(
  parameter int MAX_TILE_WIDTH  = ckse_pkg::MAX_TILE_WIDTH_DEF,
  parameter int MAX_FRAME_WIDTH = ckse_pkg::MAX_FRAME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port, one register per transaction
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pixel_value_i,
  input  logic        row_end_i,
  input  logic        tile_end_i,
  // record output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  record_kind_o,
  output logic [9:0]  byte_offset_o,
  output logic [31:0] record_value_o,
  output logic        last_of_run_o
);

  ckse_pkg::desc_t       push_desc, head_desc;
  ckse_pkg::queue_stat_t q_stat;
  logic                  push, pop;

  // front end: classifies each pixel and builds the record descriptor combinationally
  ckse_front #(
    .MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .row_end_i     (row_end_i),
    .tile_end_i    (tile_end_i),
    .q_stat_i      (q_stat),
    .q_push_o      (push),
    .q_desc_o      (push_desc)
  );

  // pixels that make no record never enter the queue
  ckse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head_desc),
    .stat_o      (q_stat)
  );

  // back end: walks the descriptor slots, one record per output transaction
  ckse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_desc),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_kind_o  (record_kind_o),
    .byte_offset_o  (byte_offset_o),
    .record_value_o (record_value_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ===== test/ckse_record_checker.sv =====
// record predictor and scoreboard for the color key sprite store encoder
`timescale 1ns / 1ps

module ckse_record_checker
  import ckse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] pixel_value_i,
  input  logic        row_end_i,
  input  logic        tile_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  record_kind_i,
  input  logic [9:0]  byte_offset_i,
  input  logic [31:0] record_value_i,
  input  logic        last_of_run_i,
  output int          pixels_taken_o,
  output int          records_taken_o,
  output int          records_waiting_o,
  output int          mismatch_count_o
);

  typedef struct packed {
    record_kind_e kind;
    logic [9:0]   offset;
    logic [31:0]  value;
    logic         is_last;
  } sprite_record_t;

  // configuration copy
  logic [31:0] key_q;
  logic [2:0]  pixel_bytes_q;
  logic [12:0] frame_width_q;
  logic [8:0]  tile_width_q;

  // run state copy
  run_mode_e   mode_q;
  logic [31:0] advance_q;
  logic [23:0] tail_bytes_q;
  logic [1:0]  tail_count_q;
  logic [10:0] run_offset_q;

  sprite_record_t expected_records[$];

  task automatic report_mismatch(input string field, input logic [31:0] want_val,
                                 input logic [31:0] got_val);
    mismatch_count_o++;
    $display("%0t ns: %s expected %08h got %08h", $time, field, want_val, got_val);
  endtask

  function automatic void push_record(input record_kind_e kind, input logic [10:0] offset,
                                      input logic [31:0] value);
    sprite_record_t rec;
    rec.kind    = kind;
    rec.offset  = offset[9:0];
    rec.value   = value;
    rec.is_last = 1'b0;
    expected_records.push_back(rec);
  endfunction

  // out-of-range writes saturate
  function automatic void write_register(input logic [1:0] index, input logic [31:0] data);
    case (cfg_idx_e'(index))
      CFG_COLOR_KEY: begin
        key_q = data;
      end
      CFG_PIXEL_BYTES: begin
        if (data[2:0] == 3'd0) pixel_bytes_q = 3'd1;
        else if (data[2:0] > 3'd4) pixel_bytes_q = 3'd4;
        else pixel_bytes_q = data[2:0];
      end
      CFG_FRAME_WIDTH: begin
        if (data[12:0] == 13'd0) frame_width_q = 13'd1;
        else if (data[12:0] > MAX_FRAME_WIDTH_DEF) frame_width_q = 13'(MAX_FRAME_WIDTH_DEF);
        else frame_width_q = data[12:0];
      end
      CFG_TILE_WIDTH: begin
        if (data[8:0] == 9'd0) tile_width_q = 9'd1;
        else if (data[8:0] > MAX_TILE_WIDTH_DEF) tile_width_q = 9'(MAX_TILE_WIDTH_DEF);
        else tile_width_q = data[8:0];
      end
      default: ;
    endcase
  endfunction

  // leftover 1..3 bytes of an opaque run
  function automatic void flush_tail();
    case (tail_count_q)
      2'd1: push_record(KIND_BYTE, run_offset_q, {24'd0, tail_bytes_q[7:0]});
      2'd2: push_record(KIND_WORD, run_offset_q, {16'd0, tail_bytes_q[15:0]});
      2'd3: begin
        push_record(KIND_BYTE, run_offset_q, {24'd0, tail_bytes_q[7:0]});
        push_record(KIND_WORD, run_offset_q + 11'd1, {16'd0, tail_bytes_q[23:8]});
      end
      default: ;
    endcase
    tail_bytes_q = '0;
    tail_count_q = '0;
    run_offset_q = '0;
  endfunction

  function automatic void encode_pixel(input logic [31:0] value, input logic row_end,
                                       input logic tile_end);
    int          records_prior;
    int          pb;
    logic [31:0] mask;
    logic [31:0] pix;
    logic [63:0] acc;
    logic [3:0]  total;
    records_prior = expected_records.size();
    pb     = pixel_bytes_q;
    mask   = (pb >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * pb)) - 32'd1);
    pix    = value & mask;
    if (pix != (key_q & mask)) begin
      if (mode_q != RUN_OPAQUE) begin
        if (advance_q != 32'd0) push_record(KIND_ADVANCE, '0, advance_q * 32'(pb));
        advance_q    = '0;
        tail_bytes_q = '0;
        tail_count_q = '0;
        run_offset_q = '0;
        mode_q       = RUN_OPAQUE;
      end
      acc   = {40'd0, tail_bytes_q} | ({32'd0, pix} << (8 * tail_count_q));
      total = 4'(tail_count_q) + 4'(pb);
      if (total >= 4'(DWORD_BYTES)) begin
        push_record(KIND_DWORD, run_offset_q, acc[31:0]);
        run_offset_q = run_offset_q + 11'(DWORD_BYTES);
        acc          = acc >> 32;
        total        = total - 4'(DWORD_BYTES);
      end
      tail_bytes_q = acc[23:0];
      tail_count_q = total[1:0];
    end else begin
      if (mode_q == RUN_OPAQUE) flush_tail();
      mode_q = RUN_TRANSP;
    end
    advance_q = advance_q + 32'd1;

    if (row_end || tile_end) begin
      if (mode_q == RUN_OPAQUE) flush_tail();
      mode_q = RUN_NONE;
      // row-end skip, wraps when the frame is narrower than the tile
      if (!tile_end) advance_q = advance_q + 32'(frame_width_q) - 32'(tile_width_q);
    end

    if (tile_end) begin
      push_record(KIND_RETURN, '0, '0);
      advance_q    = '0;
      tail_bytes_q = '0;
      tail_count_q = '0;
      run_offset_q = '0;
      mode_q       = RUN_NONE;
    end

    if (expected_records.size() > records_prior) begin
      expected_records[expected_records.size() - 1].is_last = 1'b1;
    end
  endfunction

  task automatic check_record();
    sprite_record_t want;
    if (expected_records.size() == 0) begin
      report_mismatch("record with nothing pending, kind", '0, 32'(record_kind_i));
    end else begin
      want = expected_records.pop_front();
      if (record_kind_i !== want.kind) begin
        report_mismatch("record_kind", 32'(want.kind), 32'(record_kind_i));
      end
      if (byte_offset_i !== want.offset) begin
        report_mismatch("byte_offset", 32'(want.offset), 32'(byte_offset_i));
      end
      if (record_value_i !== want.value) begin
        report_mismatch("record_value", want.value, record_value_i);
      end
      if (last_of_run_i !== want.is_last) begin
        report_mismatch("last_of_run", 32'(want.is_last), 32'(last_of_run_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q             = COLOR_KEY_RST;
      pixel_bytes_q     = PIXEL_BYTES_RST;
      frame_width_q     = FRAME_WIDTH_RST;
      tile_width_q      = TILE_WIDTH_RST;
      mode_q            = RUN_NONE;
      advance_q         = '0;
      tail_bytes_q      = '0;
      tail_count_q      = '0;
      run_offset_q      = '0;
      expected_records.delete();
      pixels_taken_o    = 0;
      records_taken_o   = 0;
      records_waiting_o = 0;
      mismatch_count_o  = 0;
    end else begin
      // a pixel on the same edge as a register write still sees the old value
      if (in_valid_i && in_ready_i) begin
        encode_pixel(pixel_value_i, row_end_i, tile_end_i);
        pixels_taken_o++;
      end
      if (cfg_we_i) write_register(cfg_index_i, cfg_wdata_i);
      if (out_valid_i && out_ready_i) begin
        check_record();
        records_taken_o++;
      end
      records_waiting_o = expected_records.size();
    end
  end

endmodule

// ===== test/tb_color_key_sprite_store_encoder_unit.sv =====
// stimulus and verdict for the color key sprite store encoder
`timescale 1ns / 1ps

module tb_color_key_sprite_store_encoder_unit;
  import ckse_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // settle time after the last expected record has come out
  localparam int LATENCY_PAUSE = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = CFG_COLOR_KEY;
  logic [31:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [31:0] pixel_value_i = '0;
  logic        row_end_i     = 1'b0;
  logic        tile_end_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [2:0]  record_kind_o;
  logic [9:0]  byte_offset_o;
  logic [31:0] record_value_o;
  logic        last_of_run_o;

  int pixels_taken;
  int records_taken;
  int records_waiting;
  int mismatch_count;

  // steady phases: no sender gaps, receiver always ready
  bit steady = 1'b0;
  int burst_left = 0;

  color_key_sprite_store_encoder_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_value_i  (pixel_value_i),
    .row_end_i      (row_end_i),
    .tile_end_i     (tile_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_kind_o  (record_kind_o),
    .byte_offset_o  (byte_offset_o),
    .record_value_o (record_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  // watches both channels and the register port, predicts and compares
  ckse_record_checker u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .pixel_value_i     (pixel_value_i),
    .row_end_i         (row_end_i),
    .tile_end_i        (tile_end_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_kind_i     (record_kind_o),
    .byte_offset_i     (byte_offset_o),
    .record_value_i    (record_value_o),
    .last_of_run_i     (last_of_run_o),
    .pixels_taken_o    (pixels_taken),
    .records_taken_o   (records_taken),
    .records_waiting_o (records_waiting),
    .mismatch_count_o  (mismatch_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver back-pressure: a new random stall mode after each stretch of random length
  int rcv_mode = 0;
  int rcv_left = 0;
  always @(negedge clk_i) begin
    if (rcv_left == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_left = $urandom_range(8, 48);
    end
    rcv_left--;
    if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      case (rcv_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ((rcv_left % 8) < 5);
      endcase
    end
  end

  // hang detection: no transaction on either channel for too long
  int last_progress = 0;
  int quiet_cycles = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pixels_taken + records_taken != last_progress) begin
        last_progress = pixels_taken + records_taken;
        quiet_cycles  = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // one pixel transaction; gaps open only between bursts
  task automatic send_pixel(input logic [31:0] value, input logic row_end, input logic tile_end);
    int gap;
    int start;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start = pixels_taken;
    in_valid_i    <= 1'b1;
    pixel_value_i <= value;
    row_end_i     <= row_end;
    tile_end_i    <= tile_end;
    @(negedge clk_i);
    while (pixels_taken == start) @(negedge clk_i);
  endtask

  // hold off the sender until every predicted record has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (records_waiting != 0);
  endtask

  // drain, wait the settle pause, then write all registers
  task automatic configure(input logic [31:0] key, input logic [31:0] pb_raw,
                           input logic [31:0] fw_raw, input logic [31:0] tw_raw);
    drain();
    repeat (LATENCY_PAUSE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_COLOR_KEY;
    cfg_wdata_i <= key;
    @(negedge clk_i);
    cfg_index_i <= CFG_PIXEL_BYTES;
    cfg_wdata_i <= pb_raw;
    @(negedge clk_i);
    cfg_index_i <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= fw_raw;
    @(negedge clk_i);
    cfg_index_i <= CFG_TILE_WIDTH;
    cfg_wdata_i <= tw_raw;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    burst_left = 0;
  endtask

  // transparent pixels keep junk above the compared bytes
  function automatic logic [31:0] pick_pixel(input logic [31:0] mask, input logic [31:0] key,
                                             input int transp_pct);
    if ($urandom_range(0, 99) < transp_pct) return (key & mask) | ($urandom & ~mask);
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed tiles of short rows, with some loose pixels with random marks
  task automatic random_tiles(input int count, input int pb, input logic [31:0] key,
                              input int transp_pct);
    int          sent;
    int          rows;
    int          len;
    logic [31:0] mask;
    logic        te;
    mask = (pb >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * pb)) - 32'd1);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        send_pixel(pick_pixel(mask, key, transp_pct), ($urandom_range(0, 3) == 0),
                   ($urandom_range(0, 5) == 0));
        sent++;
      end else begin
        rows = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
          for (int c = 0; c < len; c++) begin
            te = (c == len - 1) && (r == rows - 1);
            // the tile end alone also closes its row
            send_pixel(pick_pixel(mask, key, transp_pct),
                       (c == len - 1) && (!te || $urandom_range(0, 1)), te);
            sent++;
          end
        end
      end
      if ($urandom_range(0, 24) == 0) drain();
    end
  endtask

  logic [31:0] rand_key;

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: three-byte pixels reach every record kind; key compared on low bytes only
    configure(32'hFFA5_A5A5, 32'd3, 32'd8, 32'd4);
    send_pixel(32'h0000_0000, 1'b0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_pixel(32'h12A5_A5A5, 1'b0, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b1, 1'b0);
    send_pixel(32'hFFA5_A5A5, 1'b0, 1'b0);
    send_pixel(32'h0001_0203, 1'b0, 1'b0);
    send_pixel(32'h0004_0506, 1'b0, 1'b0);
    send_pixel(32'h0007_0809, 1'b1, 1'b0);
    // transparent last row: trailing advance dropped, return only
    send_pixel(32'h12A5_A5A5, 1'b0, 1'b0);
    send_pixel(32'h00A5_A5A5, 1'b0, 1'b0);
    send_pixel(32'hFFA5_A5A5, 1'b0, 1'b0);
    send_pixel(32'h77A5_A5A5, 1'b0, 1'b1);
    // one-pixel tile with both marks
    send_pixel(32'h00AB_CDEF, 1'b1, 1'b1);
    // tile end without row end
    send_pixel(32'h00A5_A5A5, 1'b0, 1'b0);
    send_pixel(32'h0012_3456, 1'b0, 1'b1);
    // near-key values are opaque
    send_pixel(32'h00A5_A5A4, 1'b0, 1'b0);
    send_pixel(32'h00A5_A5A6, 1'b0, 1'b0);
    send_pixel(32'h0000_0001, 1'b0, 1'b0);
    send_pixel(32'h00A5_A5A5, 1'b1, 1'b0);
    send_pixel(32'hFFA5_A5A5, 1'b1, 1'b1);

    // pixel_bytes 0 taken as 1, default widths
    configure(32'h0000_0000, 32'd0, 32'd320, 32'd16);
    random_tiles(20, 1, 32'h0000_0000, 40);

    // steady stretch; zero widths saturate to 1
    rand_key = $urandom;
    steady = 1'b1;
    configure(rand_key, 32'd2, 32'd0, 32'd0);
    random_tiles(20, 2, rand_key, 35);
    drain();
    steady = 1'b0;

    // pixel_bytes 7 taken as 4, both widths above their maxima
    configure(32'hFFFF_FFFF, 32'd7, 32'h0000_1FFF, 32'h0000_01FF);
    random_tiles(20, 4, 32'hFFFF_FFFF, 40);

    // frame narrower than tile: row-end skip wraps
    rand_key = $urandom;
    configure(rand_key, 32'd3, 32'd3, 32'd200);
    random_tiles(20, 3, rand_key, 40);

    // one long opaque row of four-byte pixels
    configure(32'h0000_0000, 32'hFFFF_FFF5, 32'd4096, 32'd1);
    for (int i = 0; i < 40; i++) begin
      send_pixel($urandom | 32'h0000_0100, (i == 39), (i == 39));
    end

    // random register words, then leave a row open across the next write
    rand_key = $urandom;
    configure(rand_key, 32'hABCD_0001, $urandom, $urandom);
    random_tiles(20, 1, rand_key, 30);
    for (int i = 0; i < 3; i++) begin
      send_pixel(pick_pixel(32'h0000_00FF, rand_key, 0), 1'b0, 1'b0);
    end

    rand_key = $urandom;
    configure(rand_key, 32'd2, 32'd640, 32'd64);
    random_tiles(20, 2, rand_key, 45);
    send_pixel($urandom, 1'b1, 1'b1);

    drain();
    repeat (LATENCY_PAUSE) @(negedge clk_i);
    if (mismatch_count == 0 && records_waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== color_key_sprite_store_encoder_unit.f =====
rtl/ckse_pkg.sv
rtl/ckse_front.sv
rtl/ckse_queue.sv
rtl/ckse_back.sv
rtl/color_key_sprite_store_encoder_unit.sv
test/ckse_record_checker.sv
test/tb_color_key_sprite_store_encoder_unit.sv
